// ===== sv/sha256md_pkg.sv =====
// SHA-256 digest core package: round constants, initial hash values and round functions.
package sha256md_pkg;

    typedef logic [31:0] word_t;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS     = 56;
    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // big sigma / small sigma
    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t ssig0(input word_t x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t init_h(input logic [2:0] idx);
        case (idx)
            3'd0:    init_h = 32'h6a09e667;
            3'd1:    init_h = 32'hbb67ae85;
            3'd2:    init_h = 32'h3c6ef372;
            3'd3:    init_h = 32'ha54ff53a;
            3'd4:    init_h = 32'h510e527f;
            3'd5:    init_h = 32'h9b05688c;
            3'd6:    init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t round_k(input logic [5:0] t);
        case (t)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// ===== sv/sha256_message_digest_core.sv =====
// SHA-256 digest core: byte input, padding sequencer, iterative round unit, word output.
// Throughput: one byte beat per cycle while a block fills; the 64th byte of every block
//   stalls input through the 64 rounds in the one round unit, then the hash add.
// After the final byte: 9 to 72 pad and length bytes, one per cycle outside compressions,
//   a compression after each full block, then eight digest beats, one per cycle when the sink is ready.
// Reset (rst_n low, asynchronous) loads the initial hash values and clears the bit count.
module sha256_message_digest_core (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] message_byte
    input  logic        s_tlast,   // final_byte
    // digest stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);
    import sha256md_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // taking message bytes
    localparam logic [2:0] S_PAD   = 3'd1;  // generating pad / length bytes
    localparam logic [2:0] S_ROUND = 3'd2;  // 64 compression rounds
    localparam logic [2:0] S_ADD   = 3'd3;  // fold working vars into hash
    localparam logic [2:0] S_OUT   = 3'd4;  // digest beats

    // padding phase
    localparam logic [2:0] PH_DATA = 3'd0;
    localparam logic [2:0] PH_MARK = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_OUT  = 3'd4;

    localparam logic [5:0] LAST_POS   = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LEN_START  = 6'(LEN_POS);

    logic [2:0]  state_reg,   state_next;
    logic [2:0]  phase_reg,   phase_next;
    logic [5:0]  pos_reg,     pos_next;     // byte position within block
    logic [5:0]  rnd_reg,     rnd_next;     // round number
    logic [2:0]  len_idx_reg, len_idx_next; // length byte, MSB first
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [63:0] bit_length_reg, bit_length_next;
    word_t       hash_reg [8];
    word_t       hash_next [8];

    // payload, no reset
    word_t       win_reg [16];              // block buffer / schedule window
    word_t       win_next [16];
    word_t       wv_reg [8];                // working variables a..h
    word_t       wv_next [8];

    logic        absorb_en;
    logic [7:0]  absorb_byte;
    logic [7:0]  pad_byte;
    logic [5:0]  len_shift;
    logic [5:0]  pos_inc;
    word_t       w_sched, w_t, t1, t2, ch, maj;

    assign pos_inc   = pos_reg + 6'd1;
    assign len_shift = {3'd7 - len_idx_reg, 3'b000};

    always_comb
    begin
        case (phase_reg)
            PH_MARK: pad_byte = PAD_MARK;
            PH_LEN:  pad_byte = 8'(bit_length_reg >> len_shift);
            default: pad_byte = 8'h00;
        endcase
    end

    // round unit; window is a shift line: [0]=W[t-16], [1]=W[t-15], [9]=W[t-7], [14]=W[t-2]
    assign w_sched = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    assign w_t     = (rnd_reg < 6'd16) ? win_reg[0] : w_sched;
    assign ch      = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
    assign maj     = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
    assign t1      = wv_reg[7] + bsig1(wv_reg[4]) + ch + w_t + round_k(rnd_reg);
    assign t2      = bsig0(wv_reg[0]) + maj;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        rnd_next        = rnd_reg;
        len_idx_next    = len_idx_reg;
        out_idx_next    = out_idx_reg;
        bit_length_next = bit_length_reg;
        hash_next       = hash_reg;
        win_next        = win_reg;
        wv_next         = wv_reg;
        absorb_en       = 1'b0;
        absorb_byte     = pad_byte;
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    absorb_en       = 1'b1;
                    absorb_byte     = s_tdata;
                    bit_length_next = bit_length_reg + 64'd8;
                    if (s_tlast)
                    begin
                        phase_next = PH_MARK;
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                absorb_en = 1'b1;
                case (phase_reg)
                    PH_LEN:
                    begin
                        len_idx_next = len_idx_reg + 3'd1;
                        if (len_idx_reg == 3'd7)
                            phase_next = PH_OUT;
                    end
                    default:
                    begin
                        if (pos_inc == LEN_START)
                        begin
                            phase_next   = PH_LEN;
                            len_idx_next = 3'd0;
                        end
                        else
                            phase_next = PH_ZERO;
                    end
                endcase
            end
            S_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    win_next[i] = win_reg[i + 1];
                win_next[15] = w_t;
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    hash_next[i] = hash_reg[i] + wv_reg[i];
                case (phase_reg)
                    PH_DATA: state_next = S_IDLE;
                    PH_OUT:
                    begin
                        state_next   = S_OUT;
                        out_idx_next = 3'd0;
                    end
                    default: state_next = S_PAD;
                endcase
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                            hash_next[i] = init_h(3'(i));
                        bit_length_next = 64'd0;
                        phase_next      = PH_DATA;
                        state_next      = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        // byte shifts into its word; the 64th byte of a block starts compression
        if (absorb_en)
        begin
            win_next[pos_reg[5:2]] = {win_reg[pos_reg[5:2]][23:0], absorb_byte};
            pos_next = pos_inc;
            if (pos_reg == LAST_POS)
            begin
                state_next = S_ROUND;
                rnd_next   = 6'd0;
                wv_next    = hash_reg;
            end
        end
    end

    assign m_tdata = hash_reg[out_idx_reg];
    assign m_tuser = out_idx_reg;
    assign m_tlast = (out_idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_DATA;
            pos_reg        <= 6'd0;
            rnd_reg        <= 6'd0;
            len_idx_reg    <= 3'd0;
            out_idx_reg    <= 3'd0;
            bit_length_reg <= 64'd0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_h(3'(i));
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            rnd_reg        <= rnd_next;
            len_idx_reg    <= len_idx_next;
            out_idx_reg    <= out_idx_next;
            bit_length_reg <= bit_length_next;
            hash_reg       <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        wv_reg  <= wv_next;
    end

endmodule
